// File: sv/qvr_pkg.sv
package qvr_pkg;

   // field widths
   localparam int COORD_WIDTH = 32;
   localparam int QUAT_WIDTH  = 32;
   localparam int QFRAC       = QUAT_WIDTH - 2;

   // datapath widths, each sized so that no step can overflow
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD1_W = QUAT_WIDTH + DIFF_W;
   localparam int SUM1_W  = PROD1_W + 2;
   localparam int PART_W  = SUM1_W - QFRAC;
   localparam int PROD2_W = PART_W + QUAT_WIDTH;
   localparam int SUM2_W  = PROD2_W + 2;
   localparam int ROT_W   = SUM2_W - QFRAC;
   localparam int FIN_W   = ROT_W + 1;

   // rounding offsets, half an lsb of the result scale
   localparam logic [SUM1_W-1:0] RND1 = SUM1_W'(1) << (QFRAC - 1);
   localparam logic [SUM2_W-1:0] RND2 = SUM2_W'(1) << (QFRAC - 1);

   // control register file
   localparam int NUM_REGS   = 7;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_DATA_W = (QUAT_WIDTH > COORD_WIDTH) ? QUAT_WIDTH : COORD_WIDTH;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_QUAT_W   = 3'd0,
      REG_QUAT_X   = 3'd1,
      REG_QUAT_Y   = 3'd2,
      REG_QUAT_Z   = 3'd3,
      REG_CENTER_X = 3'd4,
      REG_CENTER_Y = 3'd5,
      REG_CENTER_Z = 3'd6
   } csr_reg_type;

   // 1.0 in the quaternion format
   localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = {2'b01, {QFRAC{1'b0}}};

endpackage

// File: sv/quaternion_vector_rotate.sv
// channel    | valid      | stall      | payload
// -----------+------------+------------+---------------------------------------------
// request    | req_valid  | req_stall  | req_pos_x, req_pos_y, req_pos_z
// response   | rsp_valid  | rsp_stall  | rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_saturated
// csr write  | csr_write_en | (none)   | csr_index, csr_data
//
// one transaction per cycle sustained while rsp_stall is low; a request reaches the response
// through the six register stages of the datapath (difference, products, first sum,
// products, second sum, clamp)
// reset clears all stage valid flags and returns the quaternion to identity, center to 0
// a stage holds only while it is full and the stage after it holds, so bubbles collapse
// and the request side keeps flowing while a response waits, until every stage is full
module quaternion_vector_rotate
   import qvr_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_write_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_x,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_y,
   output logic signed [COORD_WIDTH-1:0] rsp_rot_z,
   output logic                          rsp_saturated
);

   // configuration: quaternion as w, x, y, z and center as x, y, z
   logic signed [QUAT_WIDTH-1:0]  quat_ff   [4];
   logic signed [COORD_WIDTH-1:0] center_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff[0]   <= QUAT_ONE;
         quat_ff[1]   <= '0;
         quat_ff[2]   <= '0;
         quat_ff[3]   <= '0;
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_QUAT_W:   quat_ff[0]   <= csr_data[QUAT_WIDTH-1:0];
            REG_QUAT_X:   quat_ff[1]   <= csr_data[QUAT_WIDTH-1:0];
            REG_QUAT_Y:   quat_ff[2]   <= csr_data[QUAT_WIDTH-1:0];
            REG_QUAT_Z:   quat_ff[3]   <= csr_data[QUAT_WIDTH-1:0];
            REG_CENTER_X: center_ff[0] <= csr_data[COORD_WIDTH-1:0];
            REG_CENTER_Y: center_ff[1] <= csr_data[COORD_WIDTH-1:0];
            REG_CENTER_Z: center_ff[2] <= csr_data[COORD_WIDTH-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // stage valid flags and per-stage load enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en_out;

   assign en_out = !rsp_valid_ff || !rsp_stall;
   assign en5    = !v5_ff || en_out;
   assign en4    = !v4_ff || en5;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;

   assign req_stall = !en1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff        <= req_valid;
         if (en2)    v2_ff        <= v1_ff;
         if (en3)    v3_ff        <= v2_ff;
         if (en4)    v4_ff        <= v3_ff;
         if (en5)    v5_ff        <= v4_ff;
         if (en_out) rsp_valid_ff <= v5_ff;
      end
   end

   // stage 1: offset from the center
   logic signed [COORD_WIDTH-1:0] pos_in [3];
   logic signed [DIFF_W-1:0]      d_in   [3];
   logic signed [DIFF_W-1:0]      d_ff   [3];

   assign pos_in[0] = req_pos_x;
   assign pos_in[1] = req_pos_y;
   assign pos_in[2] = req_pos_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = DIFF_W'(pos_in[k]) - DIFF_W'(center_ff[k]);
      end
   end

   // stage 2: products of q * (0, d), three terms per component w, x, y, z
   logic signed [PROD1_W-1:0] m1_in [4][3];
   logic signed [PROD1_W-1:0] m1_ff [4][3];

   always_comb begin
      m1_in[0][0] = PROD1_W'(quat_ff[1]) * PROD1_W'(d_ff[0]);
      m1_in[0][1] = PROD1_W'(quat_ff[2]) * PROD1_W'(d_ff[1]);
      m1_in[0][2] = PROD1_W'(quat_ff[3]) * PROD1_W'(d_ff[2]);
      m1_in[1][0] = PROD1_W'(quat_ff[0]) * PROD1_W'(d_ff[0]);
      m1_in[1][1] = PROD1_W'(quat_ff[2]) * PROD1_W'(d_ff[2]);
      m1_in[1][2] = PROD1_W'(quat_ff[3]) * PROD1_W'(d_ff[1]);
      m1_in[2][0] = PROD1_W'(quat_ff[0]) * PROD1_W'(d_ff[1]);
      m1_in[2][1] = PROD1_W'(quat_ff[3]) * PROD1_W'(d_ff[0]);
      m1_in[2][2] = PROD1_W'(quat_ff[1]) * PROD1_W'(d_ff[2]);
      m1_in[3][0] = PROD1_W'(quat_ff[0]) * PROD1_W'(d_ff[2]);
      m1_in[3][1] = PROD1_W'(quat_ff[1]) * PROD1_W'(d_ff[1]);
      m1_in[3][2] = PROD1_W'(quat_ff[2]) * PROD1_W'(d_ff[0]);
   end

   // stage 3: signed sums, round half up and rescale
   // scalar part takes all three terms negated, vector parts negate the last
   logic signed [PART_W-1:0] p_in [4];
   logic signed [PART_W-1:0] p_ff [4];

   always_comb begin
      logic signed [SUM1_W-1:0] acc;
      for (int c = 0; c < 4; c++) begin
         acc = '0;
         for (int k = 0; k < 3; k++) begin
            if (c == 0 || k == 2) begin
               acc = acc - SUM1_W'(m1_ff[c][k]);
            end else begin
               acc = acc + SUM1_W'(m1_ff[c][k]);
            end
         end
         acc     = acc + RND1;
         p_in[c] = acc[SUM1_W-1:QFRAC];
      end
   end

   // stage 4: products of p * conj(q), vector part only, four terms each
   logic signed [PROD2_W-1:0] m2_in [3][4];
   logic signed [PROD2_W-1:0] m2_ff [3][4];

   always_comb begin
      m2_in[0][0] = PROD2_W'(p_ff[0]) * PROD2_W'(quat_ff[1]);
      m2_in[0][1] = PROD2_W'(p_ff[1]) * PROD2_W'(quat_ff[0]);
      m2_in[0][2] = PROD2_W'(p_ff[2]) * PROD2_W'(quat_ff[3]);
      m2_in[0][3] = PROD2_W'(p_ff[3]) * PROD2_W'(quat_ff[2]);
      m2_in[1][0] = PROD2_W'(p_ff[0]) * PROD2_W'(quat_ff[2]);
      m2_in[1][1] = PROD2_W'(p_ff[2]) * PROD2_W'(quat_ff[0]);
      m2_in[1][2] = PROD2_W'(p_ff[3]) * PROD2_W'(quat_ff[1]);
      m2_in[1][3] = PROD2_W'(p_ff[1]) * PROD2_W'(quat_ff[3]);
      m2_in[2][0] = PROD2_W'(p_ff[0]) * PROD2_W'(quat_ff[3]);
      m2_in[2][1] = PROD2_W'(p_ff[3]) * PROD2_W'(quat_ff[0]);
      m2_in[2][2] = PROD2_W'(p_ff[1]) * PROD2_W'(quat_ff[2]);
      m2_in[2][3] = PROD2_W'(p_ff[2]) * PROD2_W'(quat_ff[1]);
   end

   // stage 5: signed sums with the first and third terms negated, rounded
   logic signed [ROT_W-1:0] r_in [3];
   logic signed [ROT_W-1:0] r_ff [3];

   always_comb begin
      logic signed [SUM2_W-1:0] acc;
      for (int c = 0; c < 3; c++) begin
         acc = '0;
         for (int k = 0; k < 4; k++) begin
            if (k == 0 || k == 2) begin
               acc = acc - SUM2_W'(m2_ff[c][k]);
            end else begin
               acc = acc + SUM2_W'(m2_ff[c][k]);
            end
         end
         acc     = acc + RND2;
         r_in[c] = acc[SUM2_W-1:QFRAC];
      end
   end

   // output stage: add the center back and clamp to the coordinate range
   logic signed [COORD_WIDTH-1:0] rot_in [3];
   logic signed [COORD_WIDTH-1:0] rot_ff [3];
   logic                          sat_in;
   logic                          sat_ff;

   always_comb begin
      logic signed [FIN_W-1:0] sum;
      sat_in = 1'b0;
      for (int c = 0; c < 3; c++) begin
         sum = FIN_W'(r_ff[c]) + FIN_W'(center_ff[c]);
         // fits when every bit above the sign position agrees
         if ((&sum[FIN_W-1:COORD_WIDTH-1]) || !(|sum[FIN_W-1:COORD_WIDTH-1])) begin
            rot_in[c] = sum[COORD_WIDTH-1:0];
         end else begin
            rot_in[c] = {sum[FIN_W-1], {(COORD_WIDTH-1){~sum[FIN_W-1]}}};
            sat_in    = 1'b1;
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (en1) d_ff  <= d_in;
      if (en2) m1_ff <= m1_in;
      if (en3) p_ff  <= p_in;
      if (en4) m2_ff <= m2_in;
      if (en5) r_ff  <= r_in;
      if (en_out) begin
         rot_ff <= rot_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_rot_x     = rot_ff[0];
   assign rsp_rot_y     = rot_ff[1];
   assign rsp_rot_z     = rot_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

// File: sv/qvr_checker.sv
module qvr_checker
   import qvr_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_WIDTH-1:0] rsp_rot_x,
   input logic signed [COORD_WIDTH-1:0] rsp_rot_y,
   input logic signed [COORD_WIDTH-1:0] rsp_rot_z,
   input logic                          rsp_saturated
);

   localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // output pipeline registers come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rot_x) && $stable(rsp_rot_y)
         && $stable(rsp_rot_z) && $stable(rsp_saturated))
      else $error("stalled response changed");

   // the pipeline only pushes back when the output itself is blocked
   a_no_false_stall: assert property (@(posedge clock)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled while output can drain");

   // a clamp flag means some coordinate sits on a range bound
   a_sat_on_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_rot_x == C_MAX || rsp_rot_x == C_MIN || rsp_rot_y == C_MAX
          || rsp_rot_y == C_MIN || rsp_rot_z == C_MAX || rsp_rot_z == C_MIN))
      else $error("saturation flag without a clamped coordinate");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);
